[hdl/rwac_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and the CORDIC arc table for the ring winding-angle classifier.
package rwac_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int COUNT_WIDTH  = 16;

  localparam int TURN_W    = 32;
  localparam int TAB_IDX_W = 5;
  localparam int STEP_W    = $clog2(CORDIC_STEPS);
  // Vectors are scaled up until one magnitude reaches 2^NORM_LIM.
  localparam int NORM_LIM  = 52;
  localparam int CORD_W    = NORM_LIM + 5;
  localparam int SHIFT_BIG = 16;
  localparam int SHIFT_MID = 4;

  localparam int REF_W    = COORD_WIDTH + 1;
  localparam int VEC_W    = COORD_WIDTH + 2;
  localparam int SUM_BITS = 33;
  localparam int DEV_W    = SUM_BITS + 1;
  localparam int TOL_W    = 12;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 16;

  localparam logic [TOL_W-1:0]       TOL_RESET    = TOL_W'(8);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = '1;
  localparam logic [COUNT_WIDTH-1:0] DEGEN_COUNT  = COUNT_WIDTH'(3);
  localparam logic [TURN_W-1:0]      ROUND_BIT    = TURN_W'(64'd1 << (TURN_W - 1 - ANGLE_BITS));
  localparam logic [TURN_W-1:0]      QUARTER_TURN = 32'h4000_0000;
  localparam logic [TURN_W-1:0]      THREE_QUARTER_TURN = 32'hC000_0000;
  localparam logic signed [DEV_W-1:0] FULL_TURN = DEV_W'(64'd1 << ANGLE_BITS);
  localparam logic signed [DEV_W-1:0] HALF_TURN = DEV_W'(64'd1 << (ANGLE_BITS - 1));

  typedef enum logic [STATUS_W-1:0] {
    RING_OUTSIDE      = 3'd0,
    RING_POSITIVE     = 3'd1,
    RING_NEGATIVE     = 3'd2,
    RING_OPEN         = 3'd3,
    RING_DEGENERATE   = 3'd4,
    RING_UNDETERMINED = 3'd5
  } ring_status_e;

  typedef enum logic [2:0] {
    CTRL_IDLE,
    CTRL_PREP,
    CTRL_ANGLE,
    CTRL_CLOSE,
    CTRL_CHECK,
    CTRL_EMIT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_NORM,
    CS_FOLD,
    CS_ITER,
    CS_DONE
  } cordic_state_e;

  typedef enum logic [1:0] {
    NP_BIG,
    NP_MID,
    NP_ONE
  } norm_phase_e;

  typedef enum logic [1:0] {
    CHK_POS,
    CHK_NEG,
    CHK_ZERO
  } check_target_e;

  typedef struct packed {
    logic                  done;
    logic [ANGLE_BITS-1:0] angle;
  } cordic_res_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [TURN_W-1:0] arc_angle(input logic [TAB_IDX_W-1:0] idx);
    logic [TURN_W-1:0] a;
    case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[hdl/ring_winding_angle_classifier_unit.sv]
`timescale 1ns / 1ps
// Top level of the ring winding-angle classifier: ring sequencer, angle sum and classification.
//
// Vertices of one ring arrive one beat each on the input channel (in_valid_i / in_stall_o);
// the beat with last_vertex_i set closes the ring and produces exactly one result beat
// (ring_status_o, vertex_total_o) on the output channel (out_valid_o / out_stall_i).
// Query point and mode are sampled with the first vertex of a ring only.
// The block works on one vertex at a time and holds in_stall_o high meanwhile. A vertex that
// needs an angle stalls the input after its beat through one setup state, the normalizing
// shifts, one fold state, 16 iterations of the CORDIC unit and one hand-back state. A vertex
// on the reference point skips the normalizing, fold and iteration steps of the CORDIC.
// The first vertex of an orientation ring needs no angle and no stall unless it closes the ring.
// Closing a ring passes through a close state, up to three tolerance compares and an emit state
// that loads the output register. A result waits in the output register while out_stall_i
// is high, and the next vertex is taken meanwhile; a ring close that finds the register still
// full waits until it drains.
// angle_tolerance is written through cfg_we_i / cfg_wdata_i; the user must write it only while
// no ring item is in work, which the block itself does not enforce.
// Reset clears the sequencer and vertex count, empties the output register and sets the
// tolerance to 8.
module ring_winding_angle_classifier_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [rwac_pkg::COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [rwac_pkg::COORD_WIDTH-1:0] vertex_y_i,
  input  logic signed [rwac_pkg::COORD_WIDTH-1:0] query_x_i,
  input  logic signed [rwac_pkg::COORD_WIDTH-1:0] query_y_i,
  input  logic                                    mode_i,
  input  logic                                    last_vertex_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [rwac_pkg::STATUS_W-1:0]           ring_status_o,
  output logic [rwac_pkg::TOTAL_W-1:0]            vertex_total_o,
  input  logic                                    cfg_we_i,
  input  logic [rwac_pkg::TOL_W-1:0]              cfg_wdata_i
);
  import rwac_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [TOL_W-1:0]              tol_q;
  logic signed [COORD_WIDTH-1:0] vx_q, vy_q, first_x_q, first_y_q;
  logic signed [REF_W-1:0]       ref_x_q, ref_y_q;
  logic [ANGLE_BITS-1:0]         prev_q;
  logic signed [SUM_BITS-1:0]    sum_q;
  logic [COUNT_WIDTH-1:0]        count_q;
  logic                          mode_q, last_q, add_step_q;
  check_target_e                 chk_q;
  ring_status_e                  status_q;
  logic [COUNT_WIDTH-1:0]        total_q;
  logic                          out_valid_q;
  logic [STATUS_W-1:0]           out_status_q;
  logic [TOTAL_W-1:0]            out_total_q;

  logic                          accept, no_angle, emit_ok, closed;
  logic                          cordic_start;
  logic signed [VEC_W-1:0]       vec_x, vec_y;
  cordic_res_t                   cordic_res;
  logic signed [ANGLE_BITS-1:0]  angle_step;
  logic signed [DEV_W-1:0]       target, dev;
  logic [DEV_W-1:0]              dev_mag;
  logic                          match, chk_last;
  ring_status_e                  close_status, hit_status;
  logic                          close_done;

  assign in_stall_o     = (state_q != CTRL_IDLE);
  assign accept         = in_valid_i && (state_q == CTRL_IDLE);
  assign no_angle       = (count_q == '0) && mode_i;
  assign emit_ok        = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign ring_status_o  = out_status_q;
  assign vertex_total_o = out_total_q;

  // Direction of 2*vertex - reference; the reference register already holds twice the point.
  assign vec_x = VEC_W'($signed({vx_q, 1'b0})) - VEC_W'(ref_x_q);
  assign vec_y = VEC_W'($signed({vy_q, 1'b0})) - VEC_W'(ref_y_q);
  assign cordic_start = (state_q == CTRL_PREP);

  rwac_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .vec_x_i (vec_x),
    .vec_y_i (vec_y),
    .res_o   (cordic_res)
  );

  // The wrapped step is simply the difference read as a signed binary angle.
  assign angle_step = $signed(cordic_res.angle - prev_q);

  assign closed = (vx_q == first_x_q) && (vy_q == first_y_q);

  always_comb begin
    close_done   = 1'b1;
    close_status = RING_UNDETERMINED;
    if (!closed) begin
      close_status = RING_OPEN;
    end else if (mode_q && count_q < DEGEN_COUNT) begin
      close_status = RING_UNDETERMINED;
    end else if (mode_q && count_q == DEGEN_COUNT) begin
      close_status = RING_DEGENERATE;
    end else begin
      close_done = 1'b0;
    end
  end

  always_comb begin
    case (chk_q)
      CHK_POS: begin
        target     = mode_q ? HALF_TURN : FULL_TURN;
        hit_status = RING_POSITIVE;
      end
      CHK_NEG: begin
        target     = mode_q ? -HALF_TURN : -FULL_TURN;
        hit_status = RING_NEGATIVE;
      end
      CHK_ZERO: begin
        target     = '0;
        hit_status = RING_OUTSIDE;
      end
      default: begin
        target     = '0;
        hit_status = RING_UNDETERMINED;
      end
    endcase
  end

  assign dev      = DEV_W'(sum_q) - target;
  assign dev_mag  = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
  assign match    = dev_mag <= DEV_W'(tol_q);
  assign chk_last = mode_q ? (chk_q == CHK_NEG) : (chk_q == CHK_ZERO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_IDLE;
      tol_q       <= TOL_RESET;
      count_q     <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (count_q != COUNT_MAX) begin
          count_q <= count_q + COUNT_WIDTH'(1);
        end
        if (count_q == '0) begin
          mode_q <= mode_i;
        end
      end else if (state_q == CTRL_CLOSE) begin
        count_q <= '0;
      end
      if (state_q == CTRL_EMIT && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CTRL_IDLE: begin
        if (accept) begin
          if (!no_angle) begin
            state_d = CTRL_PREP;
          end else if (last_vertex_i) begin
            state_d = CTRL_CLOSE;
          end
        end
      end
      CTRL_PREP: state_d = CTRL_ANGLE;
      CTRL_ANGLE: begin
        if (cordic_res.done) begin
          state_d = last_q ? CTRL_CLOSE : CTRL_IDLE;
        end
      end
      CTRL_CLOSE: state_d = close_done ? CTRL_EMIT : CTRL_CHECK;
      CTRL_CHECK: begin
        if (match || chk_last) begin
          state_d = CTRL_EMIT;
        end
      end
      CTRL_EMIT: begin
        if (emit_ok) begin
          state_d = CTRL_IDLE;
        end
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vx_q   <= vertex_x_i;
      vy_q   <= vertex_y_i;
      last_q <= last_vertex_i;
      if (count_q == '0) begin
        first_x_q  <= vertex_x_i;
        first_y_q  <= vertex_y_i;
        sum_q      <= '0;
        add_step_q <= 1'b0;
        if (mode_i) begin
          ref_x_q <= REF_W'(vertex_x_i);
          ref_y_q <= REF_W'(vertex_y_i);
          prev_q  <= '0;
        end else begin
          ref_x_q <= $signed({query_x_i, 1'b0});
          ref_y_q <= $signed({query_y_i, 1'b0});
        end
      end else if (mode_q && count_q == COUNT_WIDTH'(1)) begin
        // Second vertex of an orientation ring: the reference becomes twice the first edge midpoint.
        ref_x_q    <= ref_x_q + REF_W'(vertex_x_i);
        ref_y_q    <= ref_y_q + REF_W'(vertex_y_i);
        add_step_q <= 1'b0;
      end else begin
        add_step_q <= 1'b1;
      end
    end
    if (state_q == CTRL_ANGLE && cordic_res.done) begin
      prev_q <= cordic_res.angle;
      if (add_step_q) begin
        sum_q <= sum_q + SUM_BITS'(angle_step);
      end
    end
    if (state_q == CTRL_CLOSE) begin
      total_q  <= count_q;
      status_q <= close_status;
      chk_q    <= CHK_POS;
    end
    if (state_q == CTRL_CHECK) begin
      if (match) begin
        status_q <= hit_status;
      end else if (chk_last) begin
        status_q <= RING_UNDETERMINED;
      end else begin
        chk_q <= (chk_q == CHK_POS) ? CHK_NEG : CHK_ZERO;
      end
    end
    if (state_q == CTRL_EMIT && emit_ok) begin
      out_status_q <= status_q;
      out_total_q  <= TOTAL_W'(total_q);
    end
  end

  a_cordic_done_in_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_res.done |-> state_q == CTRL_ANGLE)
    else $error("CORDIC finished while the sequencer was not waiting for it");

  a_count_clear_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CTRL_CLOSE |=> count_q == '0)
    else $error("vertex count not cleared after ring close");

  a_emit_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTRL_EMIT && emit_ok) |=> out_valid_q && state_q == CTRL_IDLE)
    else $error("result beat not loaded into the output register");

endmodule

[hdl/rwac_cordic.sv]
`timescale 1ns / 1ps
// Iterative vectoring CORDIC that returns the binary angle of one vector.
module rwac_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [rwac_pkg::VEC_W-1:0]   vec_x_i,
  input  logic signed [rwac_pkg::VEC_W-1:0]   vec_y_i,
  output rwac_pkg::cordic_res_t               res_o
);
  import rwac_pkg::*;

  cordic_state_e state_q, state_d;
  norm_phase_e   phase_q;
  logic signed [CORD_W-1:0] x_q, y_q;
  logic [TURN_W-1:0]        z_q;
  logic [STEP_W-1:0]        step_q;
  logic                     zero_q;

  logic [CORD_W-1:0]        mag_x, mag_y, mag_or;
  logic                     fits_big, fits_mid, fits_one;
  logic signed [CORD_W-1:0] dx, dy;
  logic [TURN_W-1:0]        arc, z_round;
  logic                     in_zero;

  assign in_zero = (vec_x_i == '0) && (vec_y_i == '0);

  // The OR of both magnitudes is below a power of two exactly when the larger one is.
  assign mag_x    = x_q[CORD_W-1] ? CORD_W'(-x_q) : CORD_W'(x_q);
  assign mag_y    = y_q[CORD_W-1] ? CORD_W'(-y_q) : CORD_W'(y_q);
  assign mag_or   = mag_x | mag_y;
  assign fits_big = (mag_or >> (NORM_LIM - SHIFT_BIG)) == '0;
  assign fits_mid = (mag_or >> (NORM_LIM - SHIFT_MID)) == '0;
  assign fits_one = (mag_or >> NORM_LIM) == '0;

  assign dx  = y_q >>> step_q;
  assign dy  = x_q >>> step_q;
  assign arc = arc_angle(TAB_IDX_W'(step_q));

  assign z_round     = z_q + ROUND_BIT;
  assign res_o.done  = (state_q == CS_DONE);
  assign res_o.angle = zero_q ? '0 : z_round[TURN_W-1 -: ANGLE_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          state_d = in_zero ? CS_DONE : CS_NORM;
        end
      end
      CS_NORM: begin
        if (phase_q == NP_ONE && !fits_one) begin
          state_d = CS_FOLD;
        end
      end
      CS_FOLD: state_d = CS_ITER;
      CS_ITER: begin
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
          state_d = CS_DONE;
        end
      end
      CS_DONE: state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          x_q     <= CORD_W'(vec_x_i);
          y_q     <= CORD_W'(vec_y_i);
          z_q     <= '0;
          zero_q  <= in_zero;
          phase_q <= NP_BIG;
        end
      end
      CS_NORM: begin
        // Coarse shifts first, then single bits, until one magnitude reaches the limit.
        case (phase_q)
          NP_BIG: begin
            if (fits_big) begin
              x_q <= x_q <<< SHIFT_BIG;
              y_q <= y_q <<< SHIFT_BIG;
            end else begin
              phase_q <= NP_MID;
            end
          end
          NP_MID: begin
            if (fits_mid) begin
              x_q <= x_q <<< SHIFT_MID;
              y_q <= y_q <<< SHIFT_MID;
            end else begin
              phase_q <= NP_ONE;
            end
          end
          NP_ONE: begin
            if (fits_one) begin
              x_q <= x_q <<< 1;
              y_q <= y_q <<< 1;
            end
          end
          default: phase_q <= NP_BIG;
        endcase
      end
      CS_FOLD: begin
        // Rotate left-half vectors by a quarter turn into the right half-plane.
        if (x_q[CORD_W-1]) begin
          if (!y_q[CORD_W-1]) begin
            x_q <= y_q;
            y_q <= -x_q;
            z_q <= QUARTER_TURN;
          end else begin
            x_q <= -y_q;
            y_q <= x_q;
            z_q <= THREE_QUARTER_TURN;
          end
        end
        step_q <= '0;
      end
      CS_ITER: begin
        if (!y_q[CORD_W-1] && y_q != '0) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + arc;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - arc;
        end
        step_q <= step_q + STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the ring winding-angle classifier: ring stimulus, predictor, checks.
module tb_top;
  import rwac_pkg::*;

  localparam logic              MODE_POINT  = 1'b0;
  localparam logic              MODE_ORIENT = 1'b1;
  localparam int                SETTLE_CYCLES = 48;
  localparam int                PHASE_BEATS = 242;
  localparam real               TWO_PI = 6.283185307179586;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam longint            NORM_LIMIT = longint'(1) << 52;
  localparam longint            ANGLE_FULL = longint'(1) << ANGLE_BITS;
  localparam longint            ANGLE_HALF = longint'(1) << (ANGLE_BITS - 1);
  localparam logic [31:0]       TURN_QUARTER = 32'h4000_0000;
  localparam logic [31:0]       TURN_THREE_QUARTERS = 32'hC000_0000;
  localparam logic [31:0]       ANGLE_ROUND = 32'h1 << (31 - ANGLE_BITS);
  // Arctangent of 2^-i in units of 2^-32 turn, entry 0 rightmost.
  localparam logic [15:0][31:0] ARCTAN_TURNS = {
    32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
    32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
    32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
    32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
  };

  typedef enum {QUERY_INSIDE, QUERY_OUTSIDE, QUERY_ON_VERTEX, QUERY_ANYWHERE} query_kind_e;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] vx, vy, qx, qy;
    logic                          mode;
    logic                          last;
  } vertex_t;

  typedef struct {
    ring_status_e         status;
    logic [TOTAL_W-1:0]   total;
  } ring_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [COORD_WIDTH-1:0] vertex_x_i = '0;
  logic signed [COORD_WIDTH-1:0] vertex_y_i = '0;
  logic signed [COORD_WIDTH-1:0] query_x_i = '0;
  logic signed [COORD_WIDTH-1:0] query_y_i = '0;
  logic                          mode_i = 1'b0;
  logic                          last_vertex_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [STATUS_W-1:0]           ring_status_o;
  logic [TOTAL_W-1:0]            vertex_total_o;
  logic                          cfg_we_i = 1'b0;
  logic [TOL_W-1:0]              cfg_wdata_i = '0;

  vertex_t      pending_vertices[$];
  ring_result_t expected_rings[$];
  vertex_t      next_beat;
  ring_result_t want;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           mismatch_count = 0;

  // Predictor state.
  logic [TOL_W-1:0]              tolerance_q = TOL_RESET;
  logic signed [COORD_WIDTH-1:0] first_x = '0;
  logic signed [COORD_WIDTH-1:0] first_y = '0;
  longint                        ref_x = 0;
  longint                        ref_y = 0;
  logic [ANGLE_BITS-1:0]         prev_angle = '0;
  logic [SUM_BITS-1:0]           winding_sum = '0;
  logic [COUNT_WIDTH-1:0]        ring_len = '0;
  logic                          ring_mode_q = MODE_POINT;

  ring_winding_angle_classifier_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .query_x_i     (query_x_i),
    .query_y_i     (query_y_i),
    .mode_i        (mode_i),
    .last_vertex_i (last_vertex_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ring_status_o (ring_status_o),
    .vertex_total_o(vertex_total_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Binary angle of the vector (px, py) from a vectoring CORDIC.
  function automatic logic [ANGLE_BITS-1:0] bin_angle(input longint px, input longint py);
    longint      x, y, t, dx, dy;
    logic [31:0] z;
    int          i;
    x = px;
    y = py;
    z = '0;
    if (x == 0 && y == 0) return '0;
    while ((x < 0 ? -x : x) < NORM_LIMIT && (y < 0 ? -y : y) < NORM_LIMIT) begin
      x = x * 2;
      y = y * 2;
    end
    // Rotate the left half plane onto the right one first.
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = TURN_QUARTER;
      end else begin
        x = -y;
        y = t;
        z = TURN_THREE_QUARTERS;
      end
    end
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_TURNS[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_TURNS[i];
      end
    end
    z = z + ANGLE_ROUND;
    return z[31:32-ANGLE_BITS];
  endfunction

  function automatic bit near_turn(input longint sum, input longint target);
    longint dev;
    dev = sum - target;
    if (dev < 0) dev = -dev;
    return dev <= longint'(tolerance_q);
  endfunction

  task automatic predict_vertex(input vertex_t v);
    logic [ANGLE_BITS-1:0]        a;
    logic signed [ANGLE_BITS-1:0] d;
    longint                       s;
    ring_status_e                 verdict;
    if (ring_len == 0) begin
      first_x = v.vx;
      first_y = v.vy;
      ring_mode_q = v.mode;
      winding_sum = '0;
      if (v.mode == MODE_POINT) begin
        ref_x = 2 * longint'(v.qx);
        ref_y = 2 * longint'(v.qy);
        prev_angle = bin_angle(2 * longint'(v.vx) - ref_x, 2 * longint'(v.vy) - ref_y);
      end else begin
        ref_x = longint'(v.vx);
        ref_y = longint'(v.vy);
        prev_angle = '0;
      end
    end else if (ring_mode_q == MODE_ORIENT && ring_len == 1) begin
      // The reference becomes twice the midpoint of the first edge.
      ref_x = ref_x + longint'(v.vx);
      ref_y = ref_y + longint'(v.vy);
      prev_angle = bin_angle(2 * longint'(v.vx) - ref_x, 2 * longint'(v.vy) - ref_y);
    end else begin
      a = bin_angle(2 * longint'(v.vx) - ref_x, 2 * longint'(v.vy) - ref_y);
      d = a - prev_angle;
      winding_sum = winding_sum + {{(SUM_BITS - ANGLE_BITS){d[ANGLE_BITS-1]}}, d};
      prev_angle = a;
    end
    if (ring_len != '1) ring_len = ring_len + COUNT_WIDTH'(1);
    if (v.last) begin
      s = longint'($signed(winding_sum));
      if (v.vx != first_x || v.vy != first_y) verdict = RING_OPEN;
      else if (ring_mode_q == MODE_POINT) begin
        if (near_turn(s, ANGLE_FULL)) verdict = RING_POSITIVE;
        else if (near_turn(s, -ANGLE_FULL)) verdict = RING_NEGATIVE;
        else if (near_turn(s, 0)) verdict = RING_OUTSIDE;
        else verdict = RING_UNDETERMINED;
      end else if (ring_len < 3) verdict = RING_UNDETERMINED;
      else if (ring_len == 3) verdict = RING_DEGENERATE;
      else if (near_turn(s, ANGLE_HALF)) verdict = RING_POSITIVE;
      else if (near_turn(s, -ANGLE_HALF)) verdict = RING_NEGATIVE;
      else verdict = RING_UNDETERMINED;
      expected_rings.push_back('{verdict, ring_len});
      ring_len = '0;
      winding_sum = '0;
    end
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 32'sh0000_0000;
      3: return 32'shFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_vertex(input logic signed [31:0] vx, input logic signed [31:0] vy,
                              input logic signed [31:0] qx, input logic signed [31:0] qy,
                              input logic mode, input logic last);
    pending_vertices.push_back('{vx, vy, qx, qy, mode, last});
  endtask

  // Star-shaped polygon around a random center; the walk direction is random.
  task automatic queue_polygon(input logic ring_mode, input int sides, input bit open_end,
                               input query_kind_e query_kind);
    longint xs[$], ys[$];
    longint r, span, cx, cy, qx, qy;
    real    dir, wedge, phase, ang, rad;
    int     k;
    k = $urandom_range(2, 29);
    r = (longint'(1) << k) + longint'($urandom_range(0, (1 << k) - 1));
    span = longint'(COORD_MAX) - r;
    cx = longint'($urandom) % (2 * span + 1) - span;
    cy = longint'($urandom) % (2 * span + 1) - span;
    dir = $urandom_range(1) ? 1.0 : -1.0;
    wedge = TWO_PI / sides;
    phase = wedge * $urandom_range(0, 999) / 1000.0;
    for (k = 0; k < sides; k++) begin
      ang = phase + dir * wedge * (k + $urandom_range(0, 30) / 100.0);
      rad = r * (0.4 + $urandom_range(0, 600) / 1000.0);
      xs.push_back(cx + longint'(rad * $cos(ang)));
      ys.push_back(cy + longint'(rad * $sin(ang)));
    end
    case (query_kind)
      QUERY_INSIDE: begin
        qx = cx + longint'($urandom_range(0, 32'(r >> 5))) - (r >> 6);
        qy = cy + longint'($urandom_range(0, 32'(r >> 5))) - (r >> 6);
      end
      QUERY_OUTSIDE: begin
        // Clamping keeps the point at least one radius away along that axis.
        ang = TWO_PI * $urandom_range(0, 999) / 1000.0;
        qx = cx + longint'(2.0 * r * $cos(ang));
        qy = cy + longint'(2.0 * r * $sin(ang));
        if (qx > COORD_MAX) qx = longint'(COORD_MAX);
        if (qx < COORD_MIN) qx = longint'(COORD_MIN);
        if (qy > COORD_MAX) qy = longint'(COORD_MAX);
        if (qy < COORD_MIN) qy = longint'(COORD_MIN);
      end
      QUERY_ON_VERTEX: begin
        k = $urandom_range(0, sides - 1);
        qx = xs[k];
        qy = ys[k];
      end
      default: begin
        qx = longint'(rand_coord());
        qy = longint'(rand_coord());
      end
    endcase
    for (k = 0; k < sides; k++) begin
      if (k == 0) queue_vertex(32'(xs[k]), 32'(ys[k]), 32'(qx), 32'(qy), ring_mode, 1'b0);
      else queue_vertex(32'(xs[k]), 32'(ys[k]), rand_coord(), rand_coord(),
                        1'($urandom_range(1)), 1'b0);
    end
    queue_vertex(32'(open_end ? (xs[0] ^ 1) : xs[0]), 32'(ys[0]), rand_coord(), rand_coord(),
                 1'($urandom_range(1)), 1'b1);
  endtask

  task automatic queue_scatter_ring(input int len, input logic ring_mode, input bit closed);
    logic signed [31:0] x0, y0;
    int                 k;
    x0 = rand_coord();
    y0 = rand_coord();
    queue_vertex(x0, y0, rand_coord(), rand_coord(), ring_mode, len == 1);
    for (k = 1; k < len; k++) begin
      if (k == len - 1 && closed)
        queue_vertex(x0, y0, rand_coord(), rand_coord(), 1'($urandom_range(1)), 1'b1);
      else
        queue_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     1'($urandom_range(1)), k == len - 1);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_vertices.size() != 0 || in_valid_i || expected_rings.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Input driver: a beat is held until it is taken, then the next one may follow.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        predict_vertex('{vertex_x_i, vertex_y_i, query_x_i, query_y_i, mode_i, last_vertex_i});
      if (!in_valid_i || !in_stall_o) begin
        if (pending_vertices.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = pending_vertices.pop_front();
          vertex_x_i    <= next_beat.vx;
          vertex_y_i    <= next_beat.vy;
          query_x_i     <= next_beat.qx;
          query_y_i     <= next_beat.qy;
          mode_i        <= next_beat.mode;
          last_vertex_i <= next_beat.last;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rings.size() == 0) begin
          $error("unexpected result beat: ring_status %0d, vertex_total %0d",
                 ring_status_o, vertex_total_o);
          mismatch_count++;
        end else begin
          want = expected_rings.pop_front();
          if (ring_status_o !== want.status) begin
            $error("ring_status: expected %0d, got %0d", want.status, ring_status_o);
            mismatch_count++;
          end
          if (vertex_total_o !== want.total) begin
            $error("vertex_total: expected %0d, got %0d", want.total, vertex_total_o);
            mismatch_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int               phase, start, sides, pick;
    query_kind_e      qk;
    logic [TOL_W-1:0] tol;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rings at the reset tolerance.
    queue_vertex(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, MODE_POINT, 1'b1);
    queue_vertex(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, MODE_ORIENT, 1'b1);
    queue_vertex(7, -3, 0, 0, MODE_ORIENT, 1'b0);
    queue_vertex(7, -3, 0, 0, MODE_POINT, 1'b1);
    queue_vertex(-40, 12, 0, 0, MODE_ORIENT, 1'b0);
    queue_vertex(900, -77, 0, 0, MODE_POINT, 1'b0);
    queue_vertex(-40, 12, 0, 0, MODE_POINT, 1'b1);
    // Counterclockwise full-range square around the origin.
    queue_vertex(COORD_MIN, COORD_MIN, 0, 0, MODE_POINT, 1'b0);
    queue_vertex(COORD_MAX, COORD_MIN, 0, 0, MODE_POINT, 1'b0);
    queue_vertex(COORD_MAX, COORD_MAX, 0, 0, MODE_POINT, 1'b0);
    queue_vertex(COORD_MIN, COORD_MAX, 0, 0, MODE_POINT, 1'b0);
    queue_vertex(COORD_MIN, COORD_MIN, 0, 0, MODE_POINT, 1'b1);
    // Clockwise square, orientation mode.
    queue_vertex(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, MODE_ORIENT, 1'b0);
    queue_vertex(COORD_MIN, COORD_MAX, 0, 0, MODE_POINT, 1'b0);
    queue_vertex(COORD_MAX, COORD_MAX, 0, 0, MODE_POINT, 1'b0);
    queue_vertex(COORD_MAX, COORD_MIN, 0, 0, MODE_POINT, 1'b0);
    queue_vertex(COORD_MIN, COORD_MIN, 0, 0, MODE_POINT, 1'b1);
    // Last vertex misses the first by one unit.
    queue_vertex(5, 5, -9, 4, MODE_POINT, 1'b0);
    queue_vertex(6, 5, 0, 0, MODE_POINT, 1'b1);
    // Query point sits on the first vertex.
    queue_vertex(0, 0, 0, 0, MODE_POINT, 1'b0);
    queue_vertex(10, 0, 0, 0, MODE_POINT, 1'b0);
    queue_vertex(10, 10, 0, 0, MODE_POINT, 1'b0);
    queue_vertex(0, 0, 0, 0, MODE_POINT, 1'b1);
    // Steps of exactly half a turn.
    queue_vertex(1, 0, 0, 0, MODE_POINT, 1'b0);
    queue_vertex(-1, 0, 0, 0, MODE_POINT, 1'b0);
    queue_vertex(1, 0, 0, 0, MODE_POINT, 1'b1);
    wait_drained();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: tol = '0;
        1: tol = '1;
        2: tol = TOL_W'(8);
        3: tol = TOL_W'($urandom_range(1, 40));
        4: tol = TOL_W'($urandom_range(0, 4095));
        default: tol = TOL_W'($urandom_range(2, 16));
      endcase
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= tol;
      tolerance_q = tol;
      @(posedge clk_i);
      cfg_we_i <= 1'b0;

      @(negedge clk_i);
      send_idle_pct = (phase % 4 == 1) ? 59 : (phase % 4 == 3) ? 34 : 0;
      stall_pct     = (phase % 4 == 2) ? 59 : (phase % 4 == 3) ? 34 : 0;
      start = pending_vertices.size();
      while (pending_vertices.size() - start < PHASE_BEATS) begin
        sides = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
        pick = $urandom_range(19);
        qk = (pick < 10) ? QUERY_INSIDE : (pick < 15) ? QUERY_OUTSIDE :
             (pick < 17) ? QUERY_ON_VERTEX : QUERY_ANYWHERE;
        pick = $urandom_range(99);
        if (pick < 45) queue_polygon(MODE_POINT, sides, 1'b0, qk);
        else if (pick < 70) queue_polygon(MODE_ORIENT, sides, 1'b0, qk);
        else if (pick < 78) queue_scatter_ring($urandom_range(1, 3), MODE_ORIENT, 1'b1);
        else if (pick < 88) queue_polygon(1'($urandom_range(1)), sides, 1'b1, qk);
        else queue_scatter_ring($urandom_range(1, 6), 1'($urandom_range(1)),
                                1'($urandom_range(1)));
      end
      wait_drained();
    end

    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
